// ===== hw/rtl/trc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tick rate converter package
// Widths and rate constants shared by the converter modules.
// ----------------------------------------------------------------------------
package trc_pkg;

	localparam int TICK_W = 64;
	localparam int FREQ_W = 38;
	localparam int RATE_W = 26;
	localparam int CFG_DATA_W = 64;
	localparam int CFG_ADDR_W = 4;

	// Register index, taken from the byte address in steps of eight
	localparam logic REG_SOURCE_FREQUENCY = 1'b0;

	localparam logic [RATE_W-1:0] CPU_COUNTER_RATE = RATE_W'(46875000);
	localparam logic [RATE_W-1:0] MICRO_RATE = RATE_W'(1000000);

	typedef logic [TICK_W-1:0] tick_t;
	typedef logic [FREQ_W-1:0] freq_t;
	typedef logic [RATE_W-1:0] rate_t;

endpackage

// ===== hw/rtl/trc_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tick rate converter channels
// Valid/ready channels for tick items and converted result items.
// ----------------------------------------------------------------------------
interface trc_in_if;
	import trc_pkg::*;

	logic valid;
	logic ready;
	tick_t elapsed_ticks;

	modport source (output valid, output elapsed_ticks, input ready);
	modport sink (input valid, input elapsed_ticks, output ready);
endinterface

interface trc_out_if;
	import trc_pkg::*;

	logic valid;
	logic ready;
	tick_t cpu_counter_value;
	tick_t elapsed_microseconds;

	modport source (output valid, output cpu_counter_value, output elapsed_microseconds,
		input ready);
	modport sink (input valid, input cpu_counter_value, input elapsed_microseconds,
		output ready);
endinterface

// ===== hw/rtl/trc_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tick rate converter configuration registers
// APB-style register port holding the source frequency.
// ----------------------------------------------------------------------------
module trc_cfg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [trc_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [trc_pkg::CFG_DATA_W-1:0] pwdata,
	output logic [trc_pkg::CFG_DATA_W-1:0] prdata,
	output logic                          pready,
	output trc_pkg::freq_t                source_frequency
);
	import trc_pkg::*;

	freq_t freq_q;
	logic  hit;

	// Decode the register index from the byte address
	assign hit = (paddr[3] == REG_SOURCE_FREQUENCY);

	// Write on the access cycle; upper bits of the data are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			freq_q <= '0;
		end else if (psel && penable && pwrite && hit) begin
			freq_q <= pwdata[FREQ_W-1:0];
		end
	end

	assign prdata = hit ? {{(CFG_DATA_W-FREQ_W){1'b0}}, freq_q} : '0;
	assign pready = 1'b1;
	assign source_frequency = freq_q;

endmodule

// ===== hw/rtl/trc_qr_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tick rate converter quotient/remainder divider
// Restoring divider, one quotient bit per pipeline stage, 64 stages.
// ----------------------------------------------------------------------------
module trc_qr_div (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_valid,
	input  trc_pkg::tick_t dividend,
	input  trc_pkg::freq_t divisor,
	output logic           out_valid,
	output trc_pkg::tick_t quotient,
	output trc_pkg::freq_t remainder
);
	import trc_pkg::*;

	logic  vld_s [1:TICK_W];
	tick_t wrd_s [1:TICK_W];
	freq_t rem_s [1:TICK_W];

	for (genvar k = 0; k < TICK_W; k++) begin : g_step
		logic          src_v;
		tick_t         src_w;
		freq_t         src_r;
		logic [FREQ_W:0] trial;
		logic [FREQ_W:0] diff;
		logic          ge;

		if (k == 0) begin : g_first
			assign src_v = in_valid;
			assign src_w = dividend;
			assign src_r = '0;
		end else begin : g_next
			assign src_v = vld_s[k];
			assign src_w = wrd_s[k];
			assign src_r = rem_s[k];
		end

		// Shift in the next dividend bit and try the subtraction
		assign trial = {src_r, src_w[TICK_W-1]};
		assign diff  = trial - {1'b0, divisor};
		assign ge    = (trial >= {1'b0, divisor});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= src_v;
			end
		end

		// Quotient bits fill the word from the bottom as dividend bits leave the top
		always_ff @(posedge clk) begin
			if (en) begin
				wrd_s[k+1] <= {src_w[TICK_W-2:0], ge};
				rem_s[k+1] <= ge ? diff[FREQ_W-1:0] : trial[FREQ_W-1:0];
			end
		end
	end

	assign out_valid = vld_s[TICK_W];
	assign quotient  = wrd_s[TICK_W];
	assign remainder = rem_s[TICK_W];

endmodule

// ===== hw/rtl/trc_scale.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tick rate converter scaler
// Forms whole*rate + (rem*rate)/freq over two multiply stages and a
// 26-stage restoring divider.
// ----------------------------------------------------------------------------
module trc_scale (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_valid,
	input  trc_pkg::tick_t whole,
	input  trc_pkg::freq_t rem,
	input  trc_pkg::freq_t divisor,
	input  trc_pkg::rate_t rate,
	output logic           out_valid,
	output trc_pkg::tick_t value
);
	import trc_pkg::*;

	localparam int HALF_W = TICK_W / 2;
	localparam int LO_W = HALF_W + RATE_W;

	logic              vld_s1;
	logic [LO_W-1:0]   plo_s1;
	logic [HALF_W-1:0] phi_s1;
	tick_t             rp_s1;
	logic              vld_s2;
	tick_t             wp_s2;
	tick_t             rp_s2;
	logic [LO_W+HALF_W-1:0] phi_ext;
	logic [2*TICK_W-1:0]    rp_full;

	// Split the whole*rate product into halves; the upper half wraps
	assign phi_ext = (whole[TICK_W-1:HALF_W] * rate);
	assign rp_full = {{TICK_W{1'b0}}, {(TICK_W-FREQ_W){1'b0}}, rem} * rate;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			plo_s1 <= whole[HALF_W-1:0] * rate;
			phi_s1 <= phi_ext[HALF_W-1:0];
			rp_s1  <= rp_full[TICK_W-1:0];
			wp_s2  <= TICK_W'(plo_s1) + {phi_s1, {HALF_W{1'b0}}};
			rp_s2  <= rp_s1;
		end
	end

	// rem*rate < freq << RATE_W, so the quotient needs only RATE_W bits
	logic  vld_s [1:RATE_W];
	tick_t wrd_s [1:RATE_W];
	freq_t rmd_s [1:RATE_W];
	tick_t whl_s [1:RATE_W];

	for (genvar k = 0; k < RATE_W; k++) begin : g_step
		logic            src_v;
		tick_t           src_w;
		freq_t           src_r;
		tick_t           src_h;
		logic [FREQ_W:0] trial;
		logic [FREQ_W:0] diff;
		logic            ge;

		if (k == 0) begin : g_first
			assign src_v = vld_s2;
			assign src_w = {rp_s2[RATE_W-1:0], {(TICK_W-RATE_W){1'b0}}};
			assign src_r = rp_s2[TICK_W-1:RATE_W];
			assign src_h = wp_s2;
		end else begin : g_next
			assign src_v = vld_s[k];
			assign src_w = wrd_s[k];
			assign src_r = rmd_s[k];
			assign src_h = whl_s[k];
		end

		assign trial = {src_r, src_w[TICK_W-1]};
		assign diff  = trial - {1'b0, divisor};
		assign ge    = (trial >= {1'b0, divisor});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= src_v;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				wrd_s[k+1] <= {src_w[TICK_W-2:0], ge};
				rmd_s[k+1] <= ge ? diff[FREQ_W-1:0] : trial[FREQ_W-1:0];
				whl_s[k+1] <= src_h;
			end
		end
	end

	// Add the fractional quotient onto the wrapped whole product
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= vld_s[RATE_W];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			value <= whl_s[RATE_W] + {{(TICK_W-RATE_W){1'b0}}, wrd_s[RATE_W][RATE_W-1:0]};
		end
	end

endmodule

// ===== hw/rtl/tick_rate_converter_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tick rate converter
// Scales elapsed source ticks to a 46.875 MHz counter and to microseconds.
// ----------------------------------------------------------------------------
// Pipeline: 64 divider stages, 2 multiply stages, 26 fraction divider stages
//   and 1 output stage between an accepted item and its result.
// Throughput: one item per cycle; the whole pipeline holds while a result waits.
// Reset: asynchronous, clears valid bits and sets the source frequency to zero.
module tick_rate_converter_top (
	input  logic                           clk,
	input  logic                           arst_n,
	trc_in_if.sink                         ticks,
	trc_out_if.source                      result,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [trc_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [trc_pkg::CFG_DATA_W-1:0] pwdata,
	output logic [trc_pkg::CFG_DATA_W-1:0] prdata,
	output logic                           pready
);
	import trc_pkg::*;

	freq_t freq;
	logic  en;
	logic  div_valid;
	tick_t div_whole;
	freq_t div_rem;
	logic  cpu_valid;
	logic  usec_valid;
	tick_t cpu_value;
	tick_t usec_value;

	trc_cfg_regs u_cfg (
		.clk              (clk),
		.arst_n           (arst_n),
		.psel             (psel),
		.penable          (penable),
		.pwrite           (pwrite),
		.paddr            (paddr),
		.pwdata           (pwdata),
		.prdata           (prdata),
		.pready           (pready),
		.source_frequency (freq)
	);

	// Advance the pipeline whenever the output stage is free or being taken
	assign en = !result.valid || result.ready;
	assign ticks.ready = en;

	trc_qr_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (ticks.valid),
		.dividend  (ticks.elapsed_ticks),
		.divisor   (freq),
		.out_valid (div_valid),
		.quotient  (div_whole),
		.remainder (div_rem)
	);

	trc_scale u_cpu (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (div_valid),
		.whole     (div_whole),
		.rem       (div_rem),
		.divisor   (freq),
		.rate      (CPU_COUNTER_RATE),
		.out_valid (cpu_valid),
		.value     (cpu_value)
	);

	trc_scale u_usec (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (div_valid),
		.whole     (div_whole),
		.rem       (div_rem),
		.divisor   (freq),
		.rate      (MICRO_RATE),
		.out_valid (usec_valid),
		.value     (usec_value)
	);

	// Force zero when no source clock is configured
	assign result.valid = cpu_valid;
	assign result.cpu_counter_value = (freq == '0) ? '0 : cpu_value;
	assign result.elapsed_microseconds = (freq == '0) ? '0 : usec_value;

	a_lanes_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		cpu_valid == usec_valid)
		else $error("scaler lanes out of step");

	a_zero_freq: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && freq == '0) |->
		(result.cpu_counter_value == '0 && result.elapsed_microseconds == '0))
		else $error("non-zero result with no source clock");

	a_cfg_write: assert property (@(posedge clk) disable iff (!arst_n)
		(psel && penable && pwrite && paddr[3] == REG_SOURCE_FREQUENCY) |=>
		(freq == $past(pwdata[FREQ_W-1:0])))
		else $error("source frequency write lost");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(div_valid && !en) |=> (div_valid && $stable(div_whole)))
		else $error("divider moved while stalled");

endmodule

// ===== test/tick_rate_converter_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tick rate converter testbench
// Drives tick items through the converter under a range of source frequencies,
// predicts both scaled outputs of every item and compares them in order, with
// random idling on both channels and a long output stall.
// ----------------------------------------------------------------------------
module tick_rate_converter_top_tb;
	import trc_pkg::*;

	localparam int CLK_PERIOD = 8;
	localparam int CYCLE_LIMIT = 600000;
	localparam int DRAIN_CYCLES = 150;
	localparam int HOLD_CYCLES = 400;
	localparam logic [63:0] FREQ_MASK = (64'd1 << FREQ_W) - 64'd1;

	typedef struct {
		tick_t cpu_counter_value;
		tick_t elapsed_microseconds;
	} scaled_t;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [CFG_ADDR_W-1:0] paddr;
	logic [CFG_DATA_W-1:0] pwdata;
	logic [CFG_DATA_W-1:0] prdata;
	logic pready;

	trc_in_if ticks_ch ();
	trc_out_if result_ch ();

	tick_rate_converter_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.ticks(ticks_ch.sink),
		.result(result_ch.source),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	tick_t pending_ticks[$];
	scaled_t expected_scaled[$];
	logic [63:0] model_freq;
	int send_idle_pct;
	int recv_idle_pct;
	int hold_requests;
	int hold_served;
	int hold_left;
	int errors;
	int cycle_count;

	// Scale ticks to a target rate, splitting by the source frequency
	function automatic tick_t scale_ticks(tick_t t, logic [63:0] f, logic [63:0] rate);
		logic [63:0] whole;
		logic [63:0] rem;
		if (f == 64'd0) begin
			return '0;
		end
		whole = t / f;
		rem = t % f;
		return whole * rate + (rem * rate) / f;
	endfunction

	task automatic report_mismatch(string field, tick_t got, tick_t want);
		$display("mismatch %s: got %h expected %h", field, got, want);
		errors++;
	endtask

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// Abort on a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tick_rate_converter_top_tb failed");
			$finish;
		end
	end

	// Offer the next item, predicting its result as it leaves the queue
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ticks_ch.valid <= 1'b0;
			ticks_ch.elapsed_ticks <= '0;
		end else if (!ticks_ch.valid || ticks_ch.ready) begin
			if (pending_ticks.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				tick_t t;
				scaled_t s;
				t = pending_ticks.pop_front();
				s.cpu_counter_value = scale_ticks(t, model_freq, 64'(CPU_COUNTER_RATE));
				s.elapsed_microseconds = scale_ticks(t, model_freq, 64'(MICRO_RATE));
				expected_scaled.push_back(s);
				ticks_ch.valid <= 1'b1;
				ticks_ch.elapsed_ticks <= t;
			end else begin
				ticks_ch.valid <= 1'b0;
			end
		end
	end

	// Count down a requested long output stall
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_served <= 0;
		end else if (hold_served != hold_requests) begin
			hold_served <= hold_requests;
			hold_left <= HOLD_CYCLES;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// Accept results and compare with the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
		end else begin
			if (result_ch.valid && result_ch.ready) begin
				if (expected_scaled.size() == 0) begin
					report_mismatch("unexpected item", result_ch.cpu_counter_value, '0);
				end else begin
					scaled_t s;
					s = expected_scaled.pop_front();
					if (result_ch.cpu_counter_value !== s.cpu_counter_value)
						report_mismatch("cpu_counter_value", result_ch.cpu_counter_value,
							s.cpu_counter_value);
					if (result_ch.elapsed_microseconds !== s.elapsed_microseconds)
						report_mismatch("elapsed_microseconds",
							result_ch.elapsed_microseconds, s.elapsed_microseconds);
				end
			end
			result_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
		end
	end

	task automatic write_register(logic [CFG_ADDR_W-1:0] addr, logic [63:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if ((addr >> 3) == CFG_ADDR_W'(REG_SOURCE_FREQUENCY))
			model_freq = value & FREQ_MASK;
	endtask

	// Wait until every prediction has been matched, then let the pipeline settle
	task automatic drain();
		while (pending_ticks.size() > 0 || ticks_ch.valid || expected_scaled.size() > 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	function automatic tick_t rand_ticks(logic [63:0] f);
		tick_t w;
		w = {$urandom, $urandom};
		case ($urandom_range(3))
			0: return w;
			1: return w >> $urandom_range(63);
			2: return (f == 0) ? w : f * ($urandom_range(1000)) + 64'($urandom_range(2))
				- 64'd1;
			default: return (f == 0) ? w : w % (f * 64'd4 + 64'd1);
		endcase
	endfunction

	initial begin
		logic [63:0] freqs[8];
		logic [63:0] f;
		int total;
		freqs = '{64'd3579545, 64'd0, 64'd1, FREQ_MASK, 64'd19200000, 64'd46875000,
			64'd1000000, 64'd0};
		freqs[7] = 64'($urandom_range(1, 32'hffff_ffff)) << $urandom_range(6);
		errors = 0;
		cycle_count = 0;
		model_freq = '0;
		hold_requests = 0;
		send_idle_pct = 26;
		recv_idle_pct = 82;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Items before any write see the reset frequency of zero
		pending_ticks.push_back(64'd12345);
		pending_ticks.push_back('1);
		drain();

		// Write with bits above the register width set, then to an unknown index
		write_register(4'd0, {26'h3ff_ffff, 38'd3579545});
		write_register(4'd8, 64'd77);
		f = model_freq;
		pending_ticks.push_back('0);
		pending_ticks.push_back(64'd1);
		pending_ticks.push_back('1);
		pending_ticks.push_back(64'h8000_0000_0000_0000);
		pending_ticks.push_back(f - 64'd1);
		pending_ticks.push_back(f);
		pending_ticks.push_back(f + 64'd1);
		pending_ticks.push_back(f * 64'd1000000 - 64'd1);
		pending_ticks.push_back(64'haaaa_aaaa_aaaa_aaaa);
		pending_ticks.push_back(64'h5555_5555_5555_5555);
		drain();

		total = 0;
		for (int p = 0; p < 8; p++) begin
			if (p > 0) write_register(4'd0, freqs[p]);
			for (int n = 0; n < 235; n++) begin
				if (total == 630) begin
					send_idle_pct = 82;
					recv_idle_pct = 26;
				end
				if (total == 1260) begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
					hold_requests++;
				end
				// Pause the sender until everything has come back
				if (total == 940) drain();
				pending_ticks.push_back(rand_ticks(model_freq));
				total++;
				@(negedge clk);
			end
			drain();
		end

		drain();
		if (errors == 0) begin
			$display("tick_rate_converter_top_tb passed");
		end else begin
			$display("tick_rate_converter_top_tb failed");
		end
		$finish;
	end

endmodule

// ===== tick_rate_converter_top.f =====
hw/rtl/trc_pkg.sv
hw/rtl/trc_if.sv
hw/rtl/trc_cfg_regs.sv
hw/rtl/trc_qr_div.sv
hw/rtl/trc_scale.sv
hw/rtl/tick_rate_converter_top.sv
test/tick_rate_converter_top_tb.sv
